/* rtl/drt_pkg.sv */
// shared types and codes for the damage rectangle tracker
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_MERGE = 3'd1,
        OP_CLEAR = 3'd2,
        OP_READ  = 3'd3,
        OP_FULL  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        OC_DROPPED    = 3'd0,
        OC_COVERED    = 3'd1,
        OC_GROWN      = 3'd2,
        OC_APPENDED   = 3'd3,
        OC_OVERFLOWED = 3'd4,
        OC_DONE       = 3'd5
    } outcome_t;

    localparam logic CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic CFG_SURFACE_HEIGHT = 1'b1;

    localparam logic [12:0] SURFACE_RESET = 13'd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLIP,
        ST_SCAN,
        ST_MLOAD,
        ST_MSCAN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic contains;
        logic touches;
    } cmp_t;

endpackage

`default_nettype wire

/* rtl/drt_rect_unit.sv */
// shared rectangle unit: containment, touch test and bounding box
`timescale 1ns / 1ps
`default_nettype none

module drt_rect_unit #(
    parameter int CW = 13
) (
    input  wire logic [CW-1:0] a_x,
    input  wire logic [CW-1:0] a_y,
    input  wire logic [CW-1:0] a_w,
    input  wire logic [CW-1:0] a_h,
    input  wire logic [CW-1:0] b_x,
    input  wire logic [CW-1:0] b_y,
    input  wire logic [CW-1:0] b_w,
    input  wire logic [CW-1:0] b_h,
    output drt_pkg::cmp_t      flags,
    output logic      [CW-1:0] box_x,
    output logic      [CW-1:0] box_y,
    output logic      [CW-1:0] box_w,
    output logic      [CW-1:0] box_h
);

    logic [CW-1:0] a_r;
    logic [CW-1:0] a_b;
    logic [CW-1:0] b_r;
    logic [CW-1:0] b_b;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;

    // edges stay within the surface, so they fit the coordinate width
    always_comb
    begin
        a_r = a_x + a_w;
        a_b = a_y + a_h;
        b_r = b_x + b_w;
        b_b = b_y + b_h;

        flags.contains = (a_x >= b_x) && (a_y >= b_y) && (a_r <= b_r) && (a_b <= b_b);
        flags.touches  = (a_x <= b_r) && (a_y <= b_b) && (a_r >= b_x) && (a_b >= b_y);

        box_x  = (a_x < b_x) ? a_x : b_x;
        box_y  = (a_y < b_y) ? a_y : b_y;
        right  = (a_r > b_r) ? a_r : b_r;
        bottom = (a_b > b_b) ? a_b : b_b;
        box_w  = right - box_x;
        box_h  = bottom - box_y;
    end

endmodule

`default_nettype wire

/* rtl/damage_rect_tracker.sv */
// damage rectangle tracker: sequencer, entry memory and result register
// add: check, then done if dropped, else clip, one scan step per entry passed over, done
// merge: load, scan, done, skipped after load; read: read, done; clear, mark full: done
// one item at a time; the scan reads one memory entry per cycle through one rectangle unit
// a waiting result does not stop the next beat from being accepted
// reset empties the list, clears full damage and sets the surface to 4096 by 4096
`timescale 1ns / 1ps
`default_nettype none

module damage_rect_tracker #(
    parameter int CAPACITY = 8,
    parameter int MAX_DIM  = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic signed [15:0] rect_width,
    input  wire logic signed [15:0] rect_height,
    input  wire logic [2:0]  entry_index,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       outcome,
    output logic [2:0]       touched_index,
    output logic [11:0]      out_x,
    output logic [11:0]      out_y,
    output logic [12:0]      out_width,
    output logic [12:0]      out_height,
    output logic [3:0]       entry_count,
    output logic             full_flag
);

    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CIW = $clog2(CAPACITY + 1);
    localparam int IW  = (AW > 3) ? AW : 3;
    localparam int EW  = 4 * CW;

    drt_pkg::state_t state_reg, state_next;

    logic [12:0]            sw_reg, sw_next;
    logic [12:0]            sh_reg, sh_next;
    logic [CIW-1:0]         held_reg, held_next;
    logic                   full_reg, full_next;
    logic [CIW-1:0]         scan_reg, scan_next;

    logic signed [15:0]     rx_reg, rx_next;
    logic signed [15:0]     ry_reg, ry_next;
    logic signed [15:0]     rw_reg, rw_next;
    logic signed [15:0]     rh_reg, rh_next;
    logic [IW-1:0]          idx_reg, idx_next;

    logic [CW-1:0]          cx_reg, cx_next;
    logic [CW-1:0]          cy_reg, cy_next;
    logic [CW-1:0]          cw_reg, cw_next;
    logic [CW-1:0]          ch_reg, ch_next;

    drt_pkg::outcome_t      res_outcome_reg, res_outcome_next;
    logic [AW-1:0]          res_index_reg, res_index_next;
    logic                   res_has_reg, res_has_next;
    logic [CW-1:0]          res_x_reg, res_x_next;
    logic [CW-1:0]          res_y_reg, res_y_next;
    logic [CW-1:0]          res_w_reg, res_w_next;
    logic [CW-1:0]          res_h_reg, res_h_next;

    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             outcome_reg, outcome_next;
    logic [2:0]             touched_reg, touched_next;
    logic [11:0]            out_x_reg, out_x_next;
    logic [11:0]            out_y_reg, out_y_next;
    logic [12:0]            out_w_reg, out_w_next;
    logic [12:0]            out_h_reg, out_h_next;
    logic [3:0]             count_reg, count_next;
    logic                   flag_reg, flag_next;

    logic [EW-1:0]          mem [CAPACITY];
    logic [EW-1:0]          rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;

    logic [CW-1:0]          sw_eff;
    logic [CW-1:0]          sh_eff;
    logic [CW-1:0]          e_x, e_y, e_w, e_h;
    drt_pkg::cmp_t          cmp;
    logic [CW-1:0]          box_x, box_y, box_w, box_h;
    logic [16:0]            right_sum, bottom_sum;
    logic [CIW-1:0]         scan_inc;
    logic [IW-1:0]          in_idx;
    logic                   drop;
    logic                   read_hit;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == drt_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign touched_index = touched_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_width     = out_w_reg;
    assign out_height    = out_h_reg;
    assign entry_count   = count_reg;
    assign full_flag     = flag_reg;

    assign {e_x, e_y, e_w, e_h} = rd_data_reg;

    // surface size limited to 1..MAX_DIM
    always_comb
    begin
        if (sw_reg == 13'd0)
            sw_eff = CW'(1);
        else if (16'(sw_reg) > 16'(MAX_DIM))
            sw_eff = CW'(MAX_DIM);
        else
            sw_eff = CW'(sw_reg);

        if (sh_reg == 13'd0)
            sh_eff = CW'(1);
        else if (16'(sh_reg) > 16'(MAX_DIM))
            sh_eff = CW'(MAX_DIM);
        else
            sh_eff = CW'(sh_reg);
    end

    drt_rect_unit #(
        .CW(CW)
    ) u_rect (
        .a_x   (cx_reg),
        .a_y   (cy_reg),
        .a_w   (cw_reg),
        .a_h   (ch_reg),
        .b_x   (e_x),
        .b_y   (e_y),
        .b_w   (e_w),
        .b_h   (e_h),
        .flags (cmp),
        .box_x (box_x),
        .box_y (box_y),
        .box_w (box_w),
        .box_h (box_h)
    );

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        sw_next          = sw_reg;
        sh_next          = sh_reg;
        held_next        = held_reg;
        full_next        = full_reg;
        scan_next        = scan_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        rw_next          = rw_reg;
        rh_next          = rh_reg;
        idx_next         = idx_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cw_next          = cw_reg;
        ch_next          = ch_reg;
        res_outcome_next = res_outcome_reg;
        res_index_next   = res_index_reg;
        res_has_next     = res_has_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_w_next       = res_w_reg;
        res_h_next       = res_h_reg;
        out_valid_next   = out_valid_reg;
        outcome_next     = outcome_reg;
        touched_next     = touched_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_w_next       = out_w_reg;
        out_h_next       = out_h_reg;
        count_next       = count_reg;
        flag_next        = flag_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = {cx_reg, cy_reg, cw_reg, ch_reg};
        mem_raddr        = '0;

        in_idx     = IW'(entry_index);
        scan_inc   = scan_reg + CIW'(1);
        right_sum  = {1'b0, rx_reg} + {1'b0, rw_reg};
        bottom_sum = {1'b0, ry_reg} + {1'b0, rh_reg};
        drop       = (rw_reg <= 16'sd0) || (rh_reg <= 16'sd0) || rx_reg[15] || ry_reg[15]
                     || ($unsigned(rx_reg) >= 16'(sw_eff))
                     || ($unsigned(ry_reg) >= 16'(sh_eff));
        read_hit   = ((IW + 1)'(idx_reg) < (IW + 1)'(held_reg));

        if (cfg_valid)
        begin
            unique case (cfg_index)
                drt_pkg::CFG_SURFACE_WIDTH:  sw_next = cfg_data;
                drt_pkg::CFG_SURFACE_HEIGHT: sh_next = cfg_data;
                default:                     sw_next = sw_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            drt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rx_next      = rect_x;
                    ry_next      = rect_y;
                    rw_next      = rect_width;
                    rh_next      = rect_height;
                    idx_next     = in_idx;
                    res_has_next = 1'b0;
                    unique case (opcode)
                        drt_pkg::OP_ADD:
                            state_next = drt_pkg::ST_CHECK;
                        drt_pkg::OP_MERGE:
                            state_next = drt_pkg::ST_MLOAD;
                        drt_pkg::OP_READ:
                        begin
                            mem_raddr  = in_idx[AW-1:0];
                            state_next = drt_pkg::ST_READ;
                        end
                        drt_pkg::OP_CLEAR:
                        begin
                            held_next        = '0;
                            full_next        = 1'b0;
                            res_outcome_next = drt_pkg::OC_DONE;
                            state_next       = drt_pkg::ST_DONE;
                        end
                        drt_pkg::OP_FULL:
                        begin
                            full_next        = 1'b1;
                            res_outcome_next = drt_pkg::OC_DONE;
                            state_next       = drt_pkg::ST_DONE;
                        end
                        default:
                        begin
                            res_outcome_next = drt_pkg::OC_DROPPED;
                            state_next       = drt_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            drt_pkg::ST_CHECK:
            begin
                if (drop)
                begin
                    res_outcome_next = drt_pkg::OC_DROPPED;
                    res_has_next     = 1'b0;
                    state_next       = drt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = drt_pkg::ST_CLIP;
                end
            end

            drt_pkg::ST_CLIP:
            begin
                cx_next = CW'($unsigned(rx_reg));
                cy_next = CW'($unsigned(ry_reg));
                if (right_sum > 17'(sw_eff))
                    cw_next = sw_eff - CW'($unsigned(rx_reg));
                else
                    cw_next = CW'($unsigned(rw_reg));
                if (bottom_sum > 17'(sh_eff))
                    ch_next = sh_eff - CW'($unsigned(ry_reg));
                else
                    ch_next = CW'($unsigned(rh_reg));
                scan_next  = '0;
                mem_raddr  = '0;
                state_next = drt_pkg::ST_SCAN;
            end

            drt_pkg::ST_SCAN:
            begin
                if (scan_reg < held_reg)
                begin
                    if (cmp.contains)
                    begin
                        res_outcome_next = drt_pkg::OC_COVERED;
                        res_index_next   = scan_reg[AW-1:0];
                        res_has_next     = 1'b1;
                        res_x_next       = e_x;
                        res_y_next       = e_y;
                        res_w_next       = e_w;
                        res_h_next       = e_h;
                        state_next       = drt_pkg::ST_DONE;
                    end
                    else if (cmp.touches)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = scan_reg[AW-1:0];
                        mem_wdata        = {box_x, box_y, box_w, box_h};
                        res_outcome_next = drt_pkg::OC_GROWN;
                        res_index_next   = scan_reg[AW-1:0];
                        res_has_next     = 1'b1;
                        res_x_next       = box_x;
                        res_y_next       = box_y;
                        res_w_next       = box_w;
                        res_h_next       = box_h;
                        state_next       = drt_pkg::ST_DONE;
                    end
                    else
                    begin
                        scan_next = scan_inc;
                        mem_raddr = scan_inc[AW-1:0];
                    end
                end
                else if (held_reg == CIW'(CAPACITY))
                begin
                    full_next        = 1'b1;
                    res_outcome_next = drt_pkg::OC_OVERFLOWED;
                    res_has_next     = 1'b0;
                    state_next       = drt_pkg::ST_DONE;
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = held_reg[AW-1:0];
                    held_next        = held_reg + CIW'(1);
                    res_outcome_next = drt_pkg::OC_APPENDED;
                    res_index_next   = held_reg[AW-1:0];
                    res_has_next     = 1'b1;
                    res_x_next       = cx_reg;
                    res_y_next       = cy_reg;
                    res_w_next       = cw_reg;
                    res_h_next       = ch_reg;
                    state_next       = drt_pkg::ST_DONE;
                end
            end

            drt_pkg::ST_MLOAD:
            begin
                cx_next = e_x;
                cy_next = e_y;
                cw_next = e_w;
                ch_next = e_h;
                if (!full_reg && (held_reg >= CIW'(2)))
                begin
                    scan_next  = CIW'(1);
                    mem_raddr  = AW'(1);
                    state_next = drt_pkg::ST_MSCAN;
                end
                else
                begin
                    res_outcome_next = drt_pkg::OC_DONE;
                    res_index_next   = '0;
                    res_has_next     = (held_reg != '0);
                    res_x_next       = e_x;
                    res_y_next       = e_y;
                    res_w_next       = e_w;
                    res_h_next       = e_h;
                    state_next       = drt_pkg::ST_DONE;
                end
            end

            drt_pkg::ST_MSCAN:
            begin
                if (scan_reg < held_reg)
                begin
                    cx_next   = box_x;
                    cy_next   = box_y;
                    cw_next   = box_w;
                    ch_next   = box_h;
                    scan_next = scan_inc;
                    mem_raddr = scan_inc[AW-1:0];
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = '0;
                    held_next        = CIW'(1);
                    res_outcome_next = drt_pkg::OC_DONE;
                    res_index_next   = '0;
                    res_has_next     = 1'b1;
                    res_x_next       = cx_reg;
                    res_y_next       = cy_reg;
                    res_w_next       = cw_reg;
                    res_h_next       = ch_reg;
                    state_next       = drt_pkg::ST_DONE;
                end
            end

            drt_pkg::ST_READ:
            begin
                res_outcome_next = drt_pkg::OC_DONE;
                res_index_next   = idx_reg[AW-1:0];
                res_has_next     = read_hit;
                res_x_next       = e_x;
                res_y_next       = e_y;
                res_w_next       = e_w;
                res_h_next       = e_h;
                state_next       = drt_pkg::ST_DONE;
            end

            drt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = res_outcome_reg;
                    touched_next   = res_has_reg ? 3'(res_index_reg) : 3'd0;
                    out_x_next     = res_has_reg ? 12'(res_x_reg) : 12'd0;
                    out_y_next     = res_has_reg ? 12'(res_y_reg) : 12'd0;
                    out_w_next     = res_has_reg ? 13'(res_w_reg) : 13'd0;
                    out_h_next     = res_has_reg ? 13'(res_h_reg) : 13'd0;
                    count_next     = 4'(held_reg);
                    flag_next      = full_reg;
                    state_next     = drt_pkg::ST_IDLE;
                end
            end

            default:
                state_next = drt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drt_pkg::ST_IDLE;
            sw_reg        <= drt_pkg::SURFACE_RESET;
            sh_reg        <= drt_pkg::SURFACE_RESET;
            held_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            held_reg      <= held_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        rx_reg          <= rx_next;
        ry_reg          <= ry_next;
        rw_reg          <= rw_next;
        rh_reg          <= rh_next;
        idx_reg         <= idx_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        cw_reg          <= cw_next;
        ch_reg          <= ch_next;
        res_outcome_reg <= res_outcome_next;
        res_index_reg   <= res_index_next;
        res_has_reg     <= res_has_next;
        res_x_reg       <= res_x_next;
        res_y_reg       <= res_y_next;
        res_w_reg       <= res_w_next;
        res_h_reg       <= res_h_next;
        outcome_reg     <= outcome_next;
        touched_reg     <= touched_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_w_reg       <= out_w_next;
        out_h_reg       <= out_h_next;
        count_reg       <= count_next;
        flag_reg        <= flag_next;
    end

endmodule

`default_nettype wire

/* bench/damage_rect_tracker_tb.sv */
// self-checking testbench for the damage rectangle tracker
`timescale 1ns / 1ps

module damage_rect_tracker_tb;

    localparam int CAPACITY       = 8;
    localparam int MAX_DIM        = 4096;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;
    localparam int PHASES         = 9;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } rect_box_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [2:0]         idx;
    } damage_op_t;

    typedef struct packed {
        drt_pkg::outcome_t outcome;
        logic [2:0]        touched;
        logic [11:0]       x;
        logic [11:0]       y;
        logic [12:0]       w;
        logic [12:0]       h;
        logic [3:0]        count;
        logic              full;
    } tracker_result_t;

    typedef struct {
        damage_op_t      item;
        bit              known;
        tracker_result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = drt_pkg::CFG_SURFACE_WIDTH;
    logic [12:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         opcode = drt_pkg::OP_ADD;
    logic signed [15:0] rect_x = '0;
    logic signed [15:0] rect_y = '0;
    logic signed [15:0] rect_width = '0;
    logic signed [15:0] rect_height = '0;
    logic [2:0]         entry_index = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  outcome;
    logic [2:0]  touched_index;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [12:0] out_width;
    logic [12:0] out_height;
    logic [3:0]  entry_count;
    logic        full_flag;

    // predictor state
    rect_box_t   damage_list [CAPACITY];
    int          held_entries = 0;
    bit          whole_damaged = 1'b0;
    logic [12:0] surf_w = drt_pkg::SURFACE_RESET;
    logic [12:0] surf_h = drt_pkg::SURFACE_RESET;

    tracker_result_t pending_results [$];
    stim_row_t       directed_rows [$];

    int mismatch_count = 0;
    int results_seen = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    damage_rect_tracker #(
        .CAPACITY (CAPACITY),
        .MAX_DIM  (MAX_DIM)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .entry_index   (entry_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .outcome       (outcome),
        .touched_index (touched_index),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_width     (out_width),
        .out_height    (out_height),
        .entry_count   (entry_count),
        .full_flag     (full_flag)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_dim(logic [12:0] v);
        if (v == 13'd0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic tracker_result_t make_result(drt_pkg::outcome_t oc, int ti, int x, int y,
                                                    int w, int h, int cnt, bit full);
        tracker_result_t r;
        r.outcome = oc;
        r.touched = 3'(ti);
        r.x       = 12'(x);
        r.y       = 12'(y);
        r.w       = 13'(w);
        r.h       = 13'(h);
        r.count   = 4'(cnt);
        r.full    = full;
        return r;
    endfunction

    function automatic tracker_result_t track_damage(damage_op_t s);
        int        sw;
        int        sh;
        int        rx;
        int        ry;
        int        rw;
        int        rh;
        int        rr;
        int        rb;
        int        er;
        int        eb;
        int        l;
        int        t;
        int        i;
        rect_box_t m;
        case (s.op)
            drt_pkg::OP_ADD:
            begin
                sw = clamp_dim(surf_w);
                sh = clamp_dim(surf_h);
                rx = int'(s.x);
                ry = int'(s.y);
                rw = int'(s.w);
                rh = int'(s.h);
                if (rw <= 0 || rh <= 0 || rx < 0 || ry < 0 || rx >= sw || ry >= sh)
                    return make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, held_entries,
                                       whole_damaged);
                if (rx + rw > sw)
                    rw = sw - rx;
                if (ry + rh > sh)
                    rh = sh - ry;
                rr = rx + rw;
                rb = ry + rh;
                for (i = 0; i < held_entries; i++)
                begin
                    er = damage_list[i].x + damage_list[i].w;
                    eb = damage_list[i].y + damage_list[i].h;
                    if (rx >= damage_list[i].x && ry >= damage_list[i].y && rr <= er && rb <= eb)
                        return make_result(drt_pkg::OC_COVERED, i, damage_list[i].x,
                                           damage_list[i].y, damage_list[i].w, damage_list[i].h,
                                           held_entries, whole_damaged);
                    if (rx <= er && ry <= eb && rr >= damage_list[i].x && rb >= damage_list[i].y)
                    begin
                        l = (rx < damage_list[i].x) ? rx : damage_list[i].x;
                        t = (ry < damage_list[i].y) ? ry : damage_list[i].y;
                        damage_list[i].x = l;
                        damage_list[i].y = t;
                        damage_list[i].w = ((rr > er) ? rr : er) - l;
                        damage_list[i].h = ((rb > eb) ? rb : eb) - t;
                        return make_result(drt_pkg::OC_GROWN, i, damage_list[i].x,
                                           damage_list[i].y, damage_list[i].w, damage_list[i].h,
                                           held_entries, whole_damaged);
                    end
                end
                if (held_entries >= CAPACITY)
                begin
                    whole_damaged = 1'b1;
                    return make_result(drt_pkg::OC_OVERFLOWED, 0, 0, 0, 0, 0, held_entries, 1'b1);
                end
                damage_list[held_entries] = '{rx, ry, rw, rh};
                held_entries++;
                return make_result(drt_pkg::OC_APPENDED, held_entries - 1, rx, ry, rw, rh,
                                   held_entries, whole_damaged);
            end
            drt_pkg::OP_MERGE:
            begin
                if (!whole_damaged && held_entries >= 2)
                begin
                    m = damage_list[0];
                    for (i = 1; i < held_entries; i++)
                    begin
                        er = m.x + m.w;
                        eb = m.y + m.h;
                        rr = damage_list[i].x + damage_list[i].w;
                        rb = damage_list[i].y + damage_list[i].h;
                        if (damage_list[i].x < m.x)
                            m.x = damage_list[i].x;
                        if (damage_list[i].y < m.y)
                            m.y = damage_list[i].y;
                        if (rr > er)
                            er = rr;
                        if (rb > eb)
                            eb = rb;
                        m.w = er - m.x;
                        m.h = eb - m.y;
                    end
                    damage_list[0] = m;
                    held_entries = 1;
                end
                if (held_entries != 0)
                    return make_result(drt_pkg::OC_DONE, 0, damage_list[0].x, damage_list[0].y,
                                       damage_list[0].w, damage_list[0].h,
                                       held_entries, whole_damaged);
                return make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 0, whole_damaged);
            end
            drt_pkg::OP_CLEAR:
            begin
                held_entries = 0;
                whole_damaged = 1'b0;
                return make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 0, 1'b0);
            end
            drt_pkg::OP_READ:
            begin
                if (int'(s.idx) < held_entries)
                    return make_result(drt_pkg::OC_DONE, int'(s.idx), damage_list[s.idx].x,
                                       damage_list[s.idx].y, damage_list[s.idx].w,
                                       damage_list[s.idx].h, held_entries, whole_damaged);
                return make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, held_entries, whole_damaged);
            end
            drt_pkg::OP_FULL:
            begin
                whole_damaged = 1'b1;
                return make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, held_entries, 1'b1);
            end
            default:
                return make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, held_entries,
                                   whole_damaged);
        endcase
    endfunction

    function automatic stim_row_t directed(logic [2:0] op, int x, int y, int w, int h, int idx,
                                           bit known, tracker_result_t want);
        stim_row_t r;
        r.item  = '{op, 16'(x), 16'(y), 16'(w), 16'(h), 3'(idx)};
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    function automatic int pick_size(int lim);
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return $urandom_range(lim / 6 + 1, 1);
        if (pick < 9)
            return $urandom_range(lim, 1);
        return $urandom_range(32767, 1);
    endfunction

    function automatic damage_op_t random_op();
        damage_op_t s;
        int         pick;
        int         sw;
        int         sh;
        s.op  = drt_pkg::OP_ADD;
        s.x   = 16'($urandom);
        s.y   = 16'($urandom);
        s.w   = 16'($urandom);
        s.h   = 16'($urandom);
        s.idx = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            s.op = drt_pkg::OP_MERGE;
        else if (pick < 12)
            s.op = drt_pkg::OP_CLEAR;
        else if (pick < 24)
            s.op = drt_pkg::OP_READ;
        else if (pick < 27)
            s.op = drt_pkg::OP_FULL;
        else if (pick < 31)
            s.op = 3'($urandom_range(7, 5));
        else if (pick >= 38)
        begin
            sw = clamp_dim(surf_w);
            sh = clamp_dim(surf_h);
            s.x = 16'($urandom_range(sw - 1, 0));
            s.y = 16'($urandom_range(sh - 1, 0));
            s.w = 16'(pick_size(sw));
            s.h = 16'(pick_size(sh));
            if ($urandom_range(19) == 0)
                s.x = 16'(sw + $urandom_range(3, 0));
            if ($urandom_range(19) == 0)
                s.y = 16'(-$urandom_range(3, 1));
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_gap_pct = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SEND:
            begin
                send_gap_pct = 47;
                recv_stall_pct <= 0;
            end
            IDLE_RECV:
            begin
                send_gap_pct = 0;
                recv_stall_pct <= 47;
            end
            default:
            begin
                send_gap_pct = 37;
                recv_stall_pct <= 37;
            end
        endcase
    endtask

    task automatic send_item(damage_op_t s, bit known, tracker_result_t want);
        tracker_result_t got;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= s.op;
        rect_x      <= s.x;
        rect_y      <= s.y;
        rect_width  <= s.w;
        rect_height <= s.h;
        entry_index <= s.idx;
        do
            @(posedge clk);
        while (!in_ready);
        got = track_damage(s);
        pending_results.push_back(known ? want : got);
    endtask

    // registers change only with the list idle
    task automatic set_surface(logic [12:0] w, logic [12:0] h);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= drt_pkg::CFG_SURFACE_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        surf_w = w;
        cfg_index <= drt_pkg::CFG_SURFACE_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        surf_h = h;
        cfg_valid <= 1'b0;
    endtask

    // receiver side, with the long hold-off served here
    always @(posedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        tracker_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat, outcome", int'(outcome), 0);
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome)
                    report_mismatch("outcome", int'(outcome), int'(want.outcome));
                if (touched_index !== want.touched)
                    report_mismatch("touched_index", int'(touched_index), int'(want.touched));
                if (out_x !== want.x)
                    report_mismatch("out_x", int'(out_x), int'(want.x));
                if (out_y !== want.y)
                    report_mismatch("out_y", int'(out_y), int'(want.y));
                if (out_width !== want.w)
                    report_mismatch("out_width", int'(out_width), int'(want.w));
                if (out_height !== want.h)
                    report_mismatch("out_height", int'(out_height), int'(want.h));
                if (entry_count !== want.count)
                    report_mismatch("entry_count", int'(entry_count), int'(want.count));
                if (full_flag !== want.full)
                    report_mismatch("full_flag", int'(full_flag), int'(want.full));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        tracker_result_t none;
        int              phase_w [PHASES];
        int              phase_h [PHASES];
        int              phase_n [PHASES];
        int              p;
        int              n;

        none = '0;
        phase_w = '{4096, 640, 0, 8191, 16, 1, 0, 100, 4096};
        phase_h = '{4096, 480, 8191, 0, 16, 1, 0, 4096, 4096};
        phase_n = '{260, 220, 80, 80, 150, 40, 200, 200, 200};
        phase_w[6] = $urandom_range(8191, 1);
        phase_h[6] = $urandom_range(8191, 1);

        directed_rows.push_back(directed(drt_pkg::OP_READ, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, -32768, 0, 1, 1, 0, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 0, 0, 0, 5, 0, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 0, 0, 5, -32768, 0, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 0, 4096, 5, 5, 0, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 0, 0, 10, 10, 0, 1,
            make_result(drt_pkg::OC_APPENDED, 0, 0, 0, 10, 10, 1, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 2, 2, 3, 3, 0, 1,
            make_result(drt_pkg::OC_COVERED, 0, 0, 0, 10, 10, 1, 0)));
        // left edge meets the entry's right edge
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 10, 0, 5, 5, 0, 1,
            make_result(drt_pkg::OC_GROWN, 0, 0, 0, 15, 10, 1, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 100, 100, 32767, 32767, 0, 1,
            make_result(drt_pkg::OC_APPENDED, 1, 100, 100, 3996, 3996, 2, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 32767, 0, 1, 1, 0, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 2, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_MERGE, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 4096, 4096, 1, 0)));
        directed_rows.push_back(directed(3'd7, -1, -1, -1, -1, 7, 1,
            make_result(drt_pkg::OC_DROPPED, 0, 0, 0, 0, 0, 1, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_FULL, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 1, 1)));
        // merge is skipped under full damage but still reports entry 0
        directed_rows.push_back(directed(drt_pkg::OP_MERGE, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 4096, 4096, 1, 1)));
        directed_rows.push_back(directed(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(directed(drt_pkg::OP_MERGE, 0, 0, 0, 0, 0, 1,
            make_result(drt_pkg::OC_DONE, 0, 0, 0, 0, 0, 0, 0)));
        for (n = 0; n < CAPACITY; n++)
            directed_rows.push_back(directed(drt_pkg::OP_ADD, 20 * n, 0, 10, 10, 0, 0, none));
        directed_rows.push_back(directed(drt_pkg::OP_ADD, 300, 300, 5, 5, 0, 1,
            make_result(drt_pkg::OC_OVERFLOWED, 0, 0, 0, 0, 0, 8, 1)));
        directed_rows.push_back(directed(drt_pkg::OP_READ, 0, 0, 0, 0, 7, 1,
            make_result(drt_pkg::OC_DONE, 7, 140, 0, 10, 10, 8, 1)));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        set_idling(IDLE_NONE);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);

        for (p = 0; p < PHASES; p++)
        begin
            set_surface(13'(phase_w[p]), 13'(phase_h[p]));
            set_idling(idle_mode_t'(p % 4));
            for (n = 0; n < phase_n[p]; n++)
            begin
                if (p == 0 && n == 40)
                    hold_ticket <= hold_ticket + 1;
                send_item(random_op(), 0, none);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
